// ===== hw/rtl/mntp_pkg.sv =====
// Shared types and character constants for the mount-table line checker
package mntp_pkg;

    // separator, punctuation, letter and digit bytes
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_DASH  = 8'h2d;
    localparam logic [7:0] CH_COMMA = 8'h2c;
    localparam logic [7:0] CH_LOW_R = 8'h72;
    localparam logic [7:0] CH_LOW_O = 8'h6f;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // token positions of interest
    localparam logic [2:0] TOK_DEVICE  = 3'd2;
    localparam logic [2:0] TOK_MOUNT   = 3'd4;
    localparam logic [2:0] TOK_OPTIONS = 3'd5;
    localparam logic [2:0] TOK_DASH_MIN = 3'd6;
    localparam logic [2:0] TOK_LAST    = 3'd7;
    localparam logic [4:0] POS_LAST    = 5'd31;

    // runtime mount path, stored as raw bytes
    localparam int PATH_LEN = 25;
    localparam logic [7:0] RT_PATH [PATH_LEN] = '{
        8'h2f, 8'h61, 8'h70, 8'h65, 8'h78, 8'h2f, 8'h63, 8'h6f, 8'h6d, 8'h2e,
        8'h61, 8'h6e, 8'h64, 8'h72, 8'h6f, 8'h69, 8'h64, 8'h2e, 8'h72, 8'h75,
        8'h6e, 8'h74, 8'h69, 8'h6d, 8'h65
    };

    // accepted filesystem names
    localparam int EXT4_LEN  = 4;
    localparam int EROFS_LEN = 5;
    localparam int F2FS_LEN  = 4;
    localparam logic [7:0] FS_EXT4  [EXT4_LEN]  = '{8'h65, 8'h78, 8'h74, 8'h34};
    localparam logic [7:0] FS_EROFS [EROFS_LEN] = '{8'h65, 8'h72, 8'h6f, 8'h66, 8'h73};
    localparam logic [7:0] FS_F2FS  [F2FS_LEN]  = '{8'h66, 8'h32, 8'h66, 8'h73};

    // block device source prefix
    localparam int PFX_LEN = 11;
    localparam logic [7:0] BLK_PREFIX [PFX_LEN] = '{
        8'h2f, 8'h64, 8'h65, 8'h76, 8'h2f, 8'h62, 8'h6c, 8'h6f, 8'h63, 8'h6b, 8'h2f
    };

    // progress of the dash search and the tokens that follow it
    typedef enum logic [4:0] {
        DASH_SEARCH   = 5'b00001,
        DASH_CAND     = 5'b00010,
        DASH_FOUND    = 5'b00100,
        DASH_FS_DONE  = 5'b01000,
        DASH_SRC_DONE = 5'b10000
    } t_dash;

    // one result of a line
    typedef struct packed {
        logic        found;
        logic [31:0] major_number;
        logic [31:0] minor_number;
        logic        read_only;
        logic        fs_type_ok;
        logic        source_is_block_dev;
    } t_result;

endpackage

// ===== hw/rtl/mntp_byte_if.sv =====
// Byte stream channel: one line byte and its end-of-line mark
interface mntp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_line;

    modport source (output valid, output text_byte, output end_of_line, input ready);
    modport sink   (input valid, input text_byte, input end_of_line, output ready);
endinterface

// ===== hw/rtl/mntp_res_if.sv =====
// Result channel: one verdict per line
interface mntp_res_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [31:0] major_number;
    logic [31:0] minor_number;
    logic        read_only;
    logic        fs_type_ok;
    logic        source_is_block_dev;

    modport source (output valid, output found, output major_number, output minor_number,
                    output read_only, output fs_type_ok, output source_is_block_dev,
                    input ready);
    modport sink   (input valid, input found, input major_number, input minor_number,
                    input read_only, input fs_type_ok, input source_is_block_dev,
                    output ready);
endinterface

// ===== hw/rtl/mntp_line_scan.sv =====
// Per-byte tokenizer and field matcher holding the line scan state
module mntp_line_scan
    import mntp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_byte,
    input  logic       i_eol,
    output t_result    o_res
);

    typedef struct packed {
        logic [2:0]  token_index;
        logic        in_token;
        logic [4:0]  char_pos;
        logic        path_run;
        logic        path_ok;
        logic [31:0] major;
        logic [31:0] minor;
        logic        colon_seen;
        logic        maj_digit;
        logic        min_digit;
        logic        dev_err;
        logic        ro_run;
        logic        ro_ok;
        t_dash       dash;
        logic        fs_ext4;
        logic        fs_erofs;
        logic        fs_f2fs;
        logic        fs_ok;
        logic        src_run;
        logic        src_ok;
    } t_scan_state;

    t_scan_state r_state;
    t_scan_state n_state;

    function automatic t_scan_state clear_state();
        t_scan_state s;
        s      = '0;
        s.dash = DASH_SEARCH;
        return s;
    endfunction

    // multiply-by-ten accumulate with digit and overflow check: {ok, value}
    function automatic logic [32:0] add_digit(logic [31:0] acc, logic [7:0] c);
        logic [35:0] prod;
        logic        is_digit;
        prod = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {32'b0, c[3:0]};
        is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
        return {is_digit && (prod[35:32] == 4'd0), prod[31:0]};
    endfunction

    function automatic t_scan_state token_start(t_scan_state s_in);
        t_scan_state s;
        s = s_in;
        s.in_token = 1'b1;
        s.char_pos = '0;
        if (s.token_index == TOK_MOUNT) begin
            s.path_run = 1'b1;
            s.path_ok  = 1'b0;
        end
        if (s.token_index == TOK_OPTIONS) begin
            s.ro_run = 1'b1;
            s.ro_ok  = 1'b0;
        end
        if (s.dash == DASH_FOUND) begin
            s.fs_ext4  = 1'b1;
            s.fs_erofs = 1'b1;
            s.fs_f2fs  = 1'b1;
            s.fs_ok    = 1'b0;
        end
        if (s.dash == DASH_FS_DONE) begin
            s.src_run = 1'b1;
            s.src_ok  = 1'b0;
        end
        return s;
    endfunction

    function automatic t_scan_state on_char(t_scan_state s_in, logic [7:0] c);
        t_scan_state s;
        logic [4:0]  p;
        logic [32:0] dg;
        s  = s_in;
        p  = s.char_pos;
        dg = add_digit(s.colon_seen ? s.minor : s.major, c);

        // device number parse
        if (s.token_index == TOK_DEVICE && !s.dev_err) begin
            if (!s.colon_seen) begin
                if (c == CH_COLON) begin
                    if (s.maj_digit) s.colon_seen = 1'b1;
                    else s.dev_err = 1'b1;
                end else if (dg[32]) begin
                    s.major     = dg[31:0];
                    s.maj_digit = 1'b1;
                end else begin
                    s.dev_err = 1'b1;
                end
            end else if (dg[32]) begin
                s.minor     = dg[31:0];
                s.min_digit = 1'b1;
            end else begin
                s.dev_err = 1'b1;
            end
        end

        // mount path compare
        if (s.token_index == TOK_MOUNT && s.path_run) begin
            if (!(p < 5'(PATH_LEN) && c == RT_PATH[p])) s.path_run = 1'b0;
        end

        // read-only option compare
        if (s.token_index == TOK_OPTIONS && s.ro_run) begin
            if (p == 5'd0) begin
                if (c != CH_LOW_R) s.ro_run = 1'b0;
            end else if (p == 5'd1) begin
                if (c != CH_LOW_O) s.ro_run = 1'b0;
            end else begin
                if (p == 5'd2 && c == CH_COMMA) s.ro_ok = 1'b1;
                s.ro_run = 1'b0;
            end
        end

        // standalone dash search
        if (s.token_index >= TOK_DASH_MIN && (s.dash == DASH_SEARCH || s.dash == DASH_CAND)) begin
            s.dash = (p == 5'd0 && c == CH_DASH) ? DASH_CAND : DASH_SEARCH;
        end

        // filesystem name compare
        if (s.dash == DASH_FOUND) begin
            if (!(p < 5'(EXT4_LEN) && c == FS_EXT4[p[1:0]])) s.fs_ext4 = 1'b0;
            if (!(p < 5'(EROFS_LEN) && c == FS_EROFS[p[2:0]])) s.fs_erofs = 1'b0;
            if (!(p < 5'(F2FS_LEN) && c == FS_F2FS[p[1:0]])) s.fs_f2fs = 1'b0;
        end

        // source prefix compare
        if (s.dash == DASH_FS_DONE && s.src_run && p < 5'(PFX_LEN)) begin
            if (c != BLK_PREFIX[p[3:0]]) begin
                s.src_run = 1'b0;
            end else if (p == 5'(PFX_LEN - 1)) begin
                s.src_run = 1'b0;
                s.src_ok  = 1'b1;
            end
        end

        if (s.char_pos != POS_LAST) s.char_pos = s.char_pos + 5'd1;
        return s;
    endfunction

    function automatic t_scan_state token_end(t_scan_state s_in);
        t_scan_state s;
        logic [4:0]  n;
        s = s_in;
        n = s.char_pos;
        if (s.token_index == TOK_MOUNT && s.path_run && n == 5'(PATH_LEN)) begin
            s.path_run = 1'b0;
            s.path_ok  = 1'b1;
        end
        if (s.token_index == TOK_OPTIONS && s.ro_run && n == 5'd2) begin
            s.ro_run = 1'b0;
            s.ro_ok  = 1'b1;
        end
        unique case (s.dash)
            DASH_CAND: begin
                s.dash = DASH_FOUND;
            end
            DASH_FOUND: begin
                s.fs_ok = ((s.fs_ext4 || s.fs_f2fs) && n == 5'(EXT4_LEN)) ||
                          (s.fs_erofs && n == 5'(EROFS_LEN));
                s.fs_ext4  = 1'b0;
                s.fs_erofs = 1'b0;
                s.fs_f2fs  = 1'b0;
                s.dash     = DASH_FS_DONE;
            end
            DASH_FS_DONE: begin
                s.dash = DASH_SRC_DONE;
            end
            default: begin
            end
        endcase
        if (s.token_index != TOK_LAST) s.token_index = s.token_index + 3'd1;
        s.in_token = 1'b0;
        return s;
    endfunction

    // next state and line verdict for the current byte
    always_comb begin
        t_scan_state s;
        logic        ok;
        s     = r_state;
        ok    = 1'b0;
        o_res = '0;
        if (i_byte == CH_SPACE || i_byte == CH_TAB) begin
            if (s.in_token) s = token_end(s);
        end else begin
            if (!s.in_token) s = token_start(s);
            s = on_char(s, i_byte);
        end
        if (i_eol) begin
            if (s.in_token) s = token_end(s);
            ok = s.path_ok && s.colon_seen && s.min_digit && !s.dev_err &&
                 s.dash != DASH_SEARCH && s.dash != DASH_CAND;
            o_res.found               = ok;
            o_res.major_number        = ok ? s.major : 32'd0;
            o_res.minor_number        = ok ? s.minor : 32'd0;
            o_res.read_only           = ok && s.ro_ok;
            o_res.fs_type_ok          = ok && s.fs_ok;
            o_res.source_is_block_dev = ok && s.src_ok;
            s = clear_state();
        end
        n_state = s;
    end

    // scan state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= clear_state();
        end else if (i_step) begin
            r_state <= n_state;
        end
    end

    // a line end leaves a fresh scan state
    a_eol_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && i_eol |=> r_state.token_index == 3'd0 && !r_state.in_token && !r_state.dev_err)
        else $error("scan state not cleared after line end");

    // a filesystem verdict exists only once the dash token and fs token are past
    a_fs_after_dash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.fs_ok |-> (r_state.dash == DASH_FS_DONE || r_state.dash == DASH_SRC_DONE))
        else $error("filesystem match without a completed dash sequence");

endmodule

// ===== hw/rtl/mountinfo_line_runtime_mount_parser_core.sv =====
// Top level: input register, line scanner and result register
// Takes one byte of a mount-table line per clock and gives one result request per line,
// which is registered when the line-end byte leaves the input register. Bytes are split
// into tokens on space or tab only; the device field is parsed as decimal major:minor
// with a shared multiply-by-ten accumulator. Sustained rate is one byte per cycle: the
// scanner updates its state combinationally from the input register, and the only
// stall comes from a line-end byte that finds the result register still occupied.
// There is no start-up clearing pass; the block takes bytes right after reset.
module mountinfo_line_runtime_mount_parser_core
    import mntp_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    mntp_byte_if.sink       i_in,
    mntp_res_if.source      o_out
);

    logic       r_in_valid;
    logic [7:0] r_byte;
    logic       r_eol;
    logic       r_out_valid;
    t_result    r_res;
    t_result    n_res;
    logic       out_free;
    logic       advance;

    // handshake: the input register drains unless a line end waits for the result slot
    assign out_free   = !r_out_valid || o_out.ready;
    assign advance    = r_in_valid && (!r_eol || out_free);
    assign i_in.ready = !r_in_valid || advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_byte <= i_in.text_byte;
            r_eol  <= i_in.end_of_line;
        end
    end

    // line scanner
    mntp_line_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_byte  (r_byte),
        .i_eol   (r_eol),
        .o_res   (n_res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_eol) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_eol) begin
            r_res <= n_res;
        end
    end

    assign o_out.valid               = r_out_valid;
    assign o_out.found               = r_res.found;
    assign o_out.major_number        = r_res.major_number;
    assign o_out.minor_number        = r_res.minor_number;
    assign o_out.read_only           = r_res.read_only;
    assign o_out.fs_type_ok          = r_res.fs_type_ok;
    assign o_out.source_is_block_dev = r_res.source_is_block_dev;

    // a rejected line carries an all-zero result
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_res.found |-> r_res.major_number == 32'd0 &&
        r_res.minor_number == 32'd0 && !r_res.read_only && !r_res.fs_type_ok &&
        !r_res.source_is_block_dev)
        else $error("rejected line with nonzero result fields");

    // a blocked line end holds its byte in the input register
    a_eol_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && r_eol && !out_free |=> r_in_valid && r_eol && $stable(r_byte))
        else $error("line end lost while result slot was busy");

    // every processed line end produces a result request
    a_eol_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_eol |=> r_out_valid)
        else $error("line end processed without a result");

endmodule

// ===== tb/tb_top.sv =====
// Self-checking bench for the mount-table line checker: directed lines, then random lines
module tb_top;
    import mntp_pkg::*;

    // markers in the directed rows that expand to the runtime mount path, whole or short by one byte
    localparam logic [7:0] MARK_PATH       = "@";
    localparam logic [7:0] MARK_SHORT_PATH = "#";
    localparam logic [7:0] CH_NEWLINE      = 8'h0a;
    localparam t_result    REJECTED        = '0;
    localparam int         TOTAL_BYTES     = 1600;

    logic i_clk;
    logic i_rst_n;

    mntp_byte_if byte_ch();
    mntp_res_if  res_ch();

    mountinfo_line_runtime_mount_parser_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (byte_ch),
        .o_out   (res_ch)
    );

    // scanner state of the line checker as predicted by the bench
    logic [2:0]  tok_idx;
    logic        in_tok;
    logic [4:0]  pos;
    logic [1:0]  path_m;
    logic [31:0] maj_acc;
    logic [31:0] min_acc;
    logic [3:0]  dev_f;
    logic [1:0]  ro_f;
    t_dash       dash_st;
    logic [3:0]  fs_c;
    logic [1:0]  src_m;

    // expected verdicts and per-line typed-in overrides
    t_result     verdict_q[$];
    bit          fixed_q[$];
    t_result     fixed_want_q[$];

    // directed table
    string       row_text[$];
    bit          row_fixed[$];
    t_result     row_want[$];

    logic [7:0]  line_buf[$];
    bit          byte_taken;
    bit          calm;
    int          errors;
    int          sent_bytes;
    int          lines_sent;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #4000000;
        $display("TEST FAILED");
        $finish;
    end

    task automatic clear_scan();
        tok_idx = '0;
        in_tok  = 1'b0;
        pos     = '0;
        path_m  = '0;
        maj_acc = '0;
        min_acc = '0;
        dev_f   = '0;
        ro_f    = '0;
        dash_st = DASH_SEARCH;
        fs_c    = '0;
        src_m   = '0;
    endtask

    // one more decimal digit: bit 32 set when the digit is legal and fits in 32 bits
    function automatic logic [32:0] add_decimal(input logic [31:0] acc, input logic [7:0] c);
        logic [35:0] wide;
        if (c < CH_ZERO || c > CH_NINE)
            return '0;
        wide = 36'(acc) * 36'd10 + 36'(c - CH_ZERO);
        if (wide > 36'hFFFF_FFFF)
            return '0;
        return {1'b1, wide[31:0]};
    endfunction

    task automatic close_token();
        logic [4:0] n;
        n = pos;
        if (tok_idx == TOK_MOUNT && path_m[0] && n == PATH_LEN)
            path_m = 2'b10;
        if (tok_idx == TOK_OPTIONS && ro_f[0] && n == 5'd2)
            ro_f = 2'b10;
        if (dash_st == DASH_CAND) begin
            dash_st = DASH_FOUND;
        end else if (dash_st == DASH_FOUND) begin
            if ((fs_c[0] && n == EXT4_LEN) || (fs_c[1] && n == EROFS_LEN) ||
                (fs_c[2] && n == F2FS_LEN))
                fs_c = 4'b1000;
            else
                fs_c = 4'b0000;
            dash_st = DASH_FS_DONE;
        end else if (dash_st == DASH_FS_DONE) begin
            dash_st = DASH_SRC_DONE;
        end
        if (tok_idx < TOK_LAST)
            tok_idx = tok_idx + 3'd1;
        in_tok = 1'b0;
    endtask

    // advance the predicted scanner by one accepted byte, queue a verdict at line end
    task automatic scan_text_byte(input logic [7:0] c, input logic eol);
        logic [4:0]  p;
        logic [32:0] nxt;
        bit          ok;
        bit          fixed;
        t_result     fixed_want;
        t_result     r;
        if (c == CH_SPACE || c == CH_TAB) begin
            if (in_tok)
                close_token();
        end else begin
            // token opens
            if (!in_tok) begin
                in_tok = 1'b1;
                pos    = '0;
                if (tok_idx == TOK_MOUNT)
                    path_m = 2'b01;
                if (tok_idx == TOK_OPTIONS)
                    ro_f = 2'b01;
                if (dash_st == DASH_FOUND)
                    fs_c = 4'b0111;
                if (dash_st == DASH_FS_DONE)
                    src_m = 2'b01;
            end
            p = pos;
            // device field major:minor
            if (tok_idx == TOK_DEVICE && !dev_f[3]) begin
                if (!dev_f[0]) begin
                    if (c == CH_COLON) begin
                        if (dev_f[1])
                            dev_f[0] = 1'b1;
                        else
                            dev_f[3] = 1'b1;
                    end else begin
                        nxt = add_decimal(maj_acc, c);
                        if (nxt[32]) begin
                            maj_acc  = nxt[31:0];
                            dev_f[1] = 1'b1;
                        end else begin
                            dev_f[3] = 1'b1;
                        end
                    end
                end else begin
                    nxt = add_decimal(min_acc, c);
                    if (nxt[32]) begin
                        min_acc  = nxt[31:0];
                        dev_f[2] = 1'b1;
                    end else begin
                        dev_f[3] = 1'b1;
                    end
                end
            end
            // mount point compare
            if (tok_idx == TOK_MOUNT && path_m[0]) begin
                if (!(p < PATH_LEN && c == RT_PATH[p]))
                    path_m[0] = 1'b0;
            end
            // read-only option
            if (tok_idx == TOK_OPTIONS && ro_f[0]) begin
                if (p == 5'd0) begin
                    if (c != CH_LOW_R)
                        ro_f[0] = 1'b0;
                end else if (p == 5'd1) begin
                    if (c != CH_LOW_O)
                        ro_f[0] = 1'b0;
                end else begin
                    if (p == 5'd2 && c == CH_COMMA)
                        ro_f[1] = 1'b1;
                    ro_f[0] = 1'b0;
                end
            end
            // standalone dash search
            if (tok_idx >= TOK_DASH_MIN && (dash_st == DASH_SEARCH || dash_st == DASH_CAND))
                dash_st = (p == 5'd0 && c == CH_DASH) ? DASH_CAND : DASH_SEARCH;
            // filesystem names
            if (dash_st == DASH_FOUND) begin
                if (!(p < EXT4_LEN && c == FS_EXT4[p[1:0]]))
                    fs_c[0] = 1'b0;
                if (!(p < EROFS_LEN && c == FS_EROFS[p[2:0]]))
                    fs_c[1] = 1'b0;
                if (!(p < F2FS_LEN && c == FS_F2FS[p[1:0]]))
                    fs_c[2] = 1'b0;
            end
            // block device prefix
            if (dash_st == DASH_FS_DONE && src_m[0] && p < PFX_LEN) begin
                if (c != BLK_PREFIX[p[3:0]])
                    src_m[0] = 1'b0;
                else if (p == PFX_LEN - 1)
                    src_m = 2'b10;
            end
            if (pos < POS_LAST)
                pos = pos + 5'd1;
        end
        // line verdict
        if (eol) begin
            if (in_tok)
                close_token();
            ok = path_m[1] && (dev_f & 4'hd) == 4'h5 &&
                 (dash_st == DASH_FOUND || dash_st == DASH_FS_DONE || dash_st == DASH_SRC_DONE);
            r.found               = ok;
            r.major_number        = ok ? maj_acc : 32'd0;
            r.minor_number        = ok ? min_acc : 32'd0;
            r.read_only           = ok && ro_f[1];
            r.fs_type_ok          = ok && fs_c[3];
            r.source_is_block_dev = ok && src_m[1];
            fixed      = fixed_q.pop_front();
            fixed_want = fixed_want_q.pop_front();
            verdict_q.push_back(fixed ? fixed_want : r);
            clear_scan();
        end
    endtask

    task automatic flag_field(input string name, input logic [31:0] want, input logic [31:0] got);
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        errors++;
    endtask

    // request monitors on both channels
    always @(posedge i_clk) begin
        t_result want;
        byte_taken <= byte_ch.valid && byte_ch.ready;
        if (i_rst_n && byte_ch.valid && byte_ch.ready)
            scan_text_byte(byte_ch.text_byte, byte_ch.end_of_line);
        if (i_rst_n && res_ch.valid === 1'b1 && res_ch.ready) begin
            if (verdict_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, got found=%0d", $time,
                         res_ch.found);
                errors++;
            end else begin
                want = verdict_q.pop_front();
                if (res_ch.found !== want.found)
                    flag_field("found", 32'(want.found), 32'(res_ch.found));
                if (res_ch.major_number !== want.major_number)
                    flag_field("major_number", want.major_number, res_ch.major_number);
                if (res_ch.minor_number !== want.minor_number)
                    flag_field("minor_number", want.minor_number, res_ch.minor_number);
                if (res_ch.read_only !== want.read_only)
                    flag_field("read_only", 32'(want.read_only), 32'(res_ch.read_only));
                if (res_ch.fs_type_ok !== want.fs_type_ok)
                    flag_field("fs_type_ok", 32'(want.fs_type_ok), 32'(res_ch.fs_type_ok));
                if (res_ch.source_is_block_dev !== want.source_is_block_dev)
                    flag_field("source_is_block_dev", 32'(want.source_is_block_dev),
                               32'(res_ch.source_is_block_dev));
            end
        end
    end

    // result side back-pressure
    always @(negedge i_clk) begin
        res_ch.ready <= calm || ($urandom_range(99) >= 36);
    end

    task automatic table_row(input string s, input bit fixed, input t_result w);
        row_text.push_back(s);
        row_fixed.push_back(fixed);
        row_want.push_back(w);
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            line_buf.push_back(s[i]);
    endtask

    task automatic add_sep();
        int n;
        n = ($urandom_range(6) == 0) ? 2 : 1;
        repeat (n) line_buf.push_back($urandom_range(1) ? CH_SPACE : CH_TAB);
    endtask

    task automatic add_path();
        for (int i = 0; i < PATH_LEN; i++)
            line_buf.push_back(RT_PATH[i]);
    endtask

    // printable bytes, never a separator
    task automatic add_word(input int maxlen);
        repeat ($urandom_range(1, maxlen)) line_buf.push_back(8'($urandom_range(33, 126)));
    endtask

    function automatic string dec_text();
        logic [31:0] v;
        case ($urandom_range(5))
            0: v = $urandom_range(9);
            1: v = $urandom_range(999);
            2: v = $urandom;
            3: v = 32'hFFFF_FFFF - $urandom_range(3);
            4: return $sformatf("00%0d", $urandom_range(99));
            default: v = $urandom_range(65535);
        endcase
        return $sformatf("%0d", v);
    endfunction

    // mostly well-formed mount entry with random content and occasional damage
    task automatic make_mount_line();
        int n_opt;
        int mark;
        line_buf.delete();
        if ($urandom_range(9) == 0)
            add_sep();
        add_text(dec_text());
        add_sep();
        add_text(dec_text());
        add_sep();
        // device field
        case ($urandom_range(11))
            0: add_text($sformatf("%0d:%s", 40'd4294967296 + $urandom_range(99), dec_text()));
            1: add_text($sformatf("%s:%0d", dec_text(), 40'd4294967296 + $urandom_range(99)));
            2: add_text({":", dec_text()});
            3: add_text({dec_text(), ":"});
            4: add_text({dec_text(), ":", dec_text(), ":", dec_text()});
            5: begin
                add_text(dec_text());
                add_word(3);
                add_text({":", dec_text()});
            end
            default: add_text({dec_text(), ":", dec_text()});
        endcase
        // root, sometimes left out to shift the token indexes
        if ($urandom_range(19) != 0) begin
            add_sep();
            if ($urandom_range(1))
                add_text("/");
            else
                add_word(40);
        end
        // mount point
        add_sep();
        case ($urandom_range(9))
            0: begin
                add_path();
                mark = line_buf.size() - PATH_LEN + $urandom_range(PATH_LEN - 1);
                line_buf[mark] = line_buf[mark] ^ (8'h01 << $urandom_range(7));
            end
            1: begin
                add_path();
                repeat ($urandom_range(1, 3)) void'(line_buf.pop_back());
            end
            2: begin
                add_path();
                add_word(3);
            end
            3: add_word(30);
            default: add_path();
        endcase
        // options
        if ($urandom_range(19) != 0) begin
            add_sep();
            case ($urandom_range(9))
                0: add_text("rw");
                1: add_text("ro,nosuid");
                2: add_text("ro,");
                3: add_text("r");
                4: add_text("rox");
                5: add_text("rw,ro");
                6: add_text("o");
                7: add_word(8);
                default: add_text("ro");
            endcase
        end
        // optional fields
        n_opt = ($urandom_range(9) == 0) ? $urandom_range(4, 7) : $urandom_range(3);
        repeat (n_opt) begin
            add_sep();
            case ($urandom_range(5))
                0: add_text($sformatf("shared:%0d", $urandom_range(99)));
                1: add_text($sformatf("master:%0d", $urandom_range(99)));
                2: add_text("-x");
                3: add_text("--");
                4: add_text("-");
                default: add_word(10);
            endcase
        end
        // separator dash
        case ($urandom_range(19))
            0: ;
            1: begin
                add_sep();
                add_text("--");
            end
            default: begin
                add_sep();
                add_text("-");
            end
        endcase
        // filesystem, source and super options
        if ($urandom_range(19) != 0) begin
            add_sep();
            case ($urandom_range(11))
                0: add_text("ext4x");
                1: add_text("ext");
                2: add_text("erof");
                3: add_text("erofs,");
                4: add_text("f2f");
                5: add_text("tmpfs");
                6: add_word(6);
                7, 8: add_text("erofs");
                9: add_text("f2fs");
                default: add_text("ext4");
            endcase
            if ($urandom_range(9) != 0) begin
                add_sep();
                case ($urandom_range(7))
                    0: add_text("/dev/block/");
                    1: add_text("/dev/block");
                    2: add_text("/dev/blockx/");
                    3: add_text("none");
                    4: add_word(20);
                    default: add_text($sformatf("/dev/block/dm-%0d", $urandom_range(99)));
                endcase
                if ($urandom_range(9) < 7) begin
                    add_sep();
                    add_text($urandom_range(1) ? "ro" : "rw,seclabel");
                end
            end
        end
        // line ending
        case ($urandom_range(9))
            0, 1, 2: line_buf.push_back(CH_NEWLINE);
            3: add_sep();
            default: ;
        endcase
        // stray byte damage
        if ($urandom_range(11) == 0)
            line_buf[$urandom_range(line_buf.size() - 1)] = 8'($urandom_range(255));
    endtask

    // raw noise of any byte value, biased toward the bytes the scanner cares about
    task automatic make_noise_line();
        line_buf.delete();
        repeat ($urandom_range(1, 30)) begin
            case ($urandom_range(9))
                0, 1, 2, 3: line_buf.push_back(8'($urandom_range(255)));
                4, 5: line_buf.push_back($urandom_range(1) ? CH_SPACE : CH_TAB);
                6, 7: line_buf.push_back(8'($urandom_range(CH_ZERO, CH_NINE)));
                8: line_buf.push_back(CH_COLON);
                default: line_buf.push_back(CH_DASH);
            endcase
        end
    endtask

    // drive one line byte by byte with random gaps
    task automatic send_line(input bit fixed, input t_result want);
        fixed_q.push_back(fixed);
        fixed_want_q.push_back(want);
        foreach (line_buf[k]) begin
            while (!calm && $urandom_range(99) < 36) begin
                byte_ch.valid <= 1'b0;
                @(negedge i_clk);
            end
            byte_ch.valid       <= 1'b1;
            byte_ch.text_byte   <= line_buf[k];
            byte_ch.end_of_line <= (k == line_buf.size() - 1);
            do @(negedge i_clk); while (!byte_taken);
            sent_bytes++;
        end
        lines_sent++;
    endtask

    task automatic wait_drained();
        byte_ch.valid <= 1'b0;
        while (verdict_q.size() != 0) @(negedge i_clk);
    endtask

    // main sequence
    initial begin
        string s;
        i_rst_n             = 1'b0;
        byte_ch.valid       = 1'b0;
        byte_ch.text_byte   = '0;
        byte_ch.end_of_line = 1'b0;
        calm                = 1'b0;
        errors              = 0;
        sent_bytes          = 0;
        lines_sent          = 0;
        clear_scan();

        // directed lines, expected verdict typed in where it is obvious
        table_row("36 35 253:5 / @ ro,nodev - ext4 /dev/block/dm-5 ro\n", 1'b1,
                  {1'b1, 32'd253, 32'd5, 3'b111});
        table_row("1 2 4294967295:4294967295 / @ rw shared:1 - erofs /dev/block/loop3", 1'b1,
                  {1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'b011});
        table_row("1 2 4294967296:1 / @ ro - ext4 /dev/block/x", 1'b1, REJECTED);
        table_row("1 2 0:4294967296 / @ ro - ext4 /dev/block/x", 1'b1, REJECTED);
        table_row("1 2 :5 / @ ro - f2fs /dev/block/a", 1'b1, REJECTED);
        table_row("1 2 7: / @ ro - f2fs /dev/block/a", 1'b1, REJECTED);
        table_row("1 2 7:8:9 / @ ro - f2fs /dev/block/a", 1'b1, REJECTED);
        table_row("1 2 7a:8 / @ ro - f2fs /dev/block/a", 1'b1, REJECTED);
        table_row("1 2 7:8 / @ - ext4 /dev/block/a", 1'b1, REJECTED);
        table_row("1 2 8:1 / @ ro -", 1'b1, {1'b1, 32'd8, 32'd1, 3'b100});
        table_row("1 2 8:1 / @", 1'b1, REJECTED);
        table_row(" \t  \t", 1'b1, REJECTED);
        table_row("-", 1'b1, REJECTED);
        table_row("1 2 3:4 / # ro - ext4 x", 1'b1, REJECTED);
        table_row("1 2 3:4 / @x ro - ext4 x", 1'b1, REJECTED);
        table_row("1 2 3:4 / @ ro -a", 1'b1, REJECTED);
        table_row("1 2 8:1 / @ rox a b c d -x - f2fs /dev/block/", 1'b0, REJECTED);
        table_row("1\t2\t0:0\t/\t@\tro,\t-\terofs\t/dev/block", 1'b0, REJECTED);
        table_row("1 2 3:4 / @ r - ext4x /dev/blocK/sda", 1'b0, REJECTED);
        table_row("1 2 3:4 /aaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaa @ ro - erofs /dev/block/sda",
                  1'b0, REJECTED);
        table_row("1 2 3:4 / @ ro - ext4\n", 1'b0, REJECTED);
        table_row("\t 1  2 0010:0020 / @ ro - ext4 /dev/block/a ", 1'b0, REJECTED);
        table_row("1 2 3:4 / @ ro -- - erofs /dev/block/z", 1'b0, REJECTED);
        table_row("9 9 1:1 / @ ro a b c d e f g - ext4 /dev/block/q", 1'b0, REJECTED);

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // walk the directed table
        foreach (row_text[i]) begin
            s = row_text[i];
            line_buf.delete();
            for (int j = 0; j < s.len(); j++) begin
                if (s[j] == MARK_PATH) begin
                    add_path();
                end else if (s[j] == MARK_SHORT_PATH) begin
                    add_path();
                    void'(line_buf.pop_back());
                end else begin
                    line_buf.push_back(s[j]);
                end
            end
            send_line(row_fixed[i], row_want[i]);
        end

        // hold off until every directed verdict is back
        wait_drained();

        // random lines, with a stretch of full throughput on both sides
        lines_sent = 0;
        while (sent_bytes < TOTAL_BYTES) begin
            calm = (lines_sent >= 1 && lines_sent < 5);
            case ($urandom_range(19))
                0: begin
                    line_buf.delete();
                    repeat ($urandom_range(1, 6))
                        line_buf.push_back($urandom_range(1) ? CH_SPACE : CH_TAB);
                end
                1, 2, 3, 4: make_noise_line();
                default: make_mount_line();
            endcase
            send_line(1'b0, REJECTED);
            if ($urandom_range(29) == 0)
                wait_drained();
        end
        calm = 1'b0;

        // drain and let the pipeline settle
        wait_drained();
        repeat (10) @(negedge i_clk);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/mntp_pkg.sv
hw/rtl/mntp_byte_if.sv
hw/rtl/mntp_res_if.sv
hw/rtl/mntp_line_scan.sv
hw/rtl/mountinfo_line_runtime_mount_parser_core.sv
tb/tb_top.sv
